### rtl/xxtea_block_cipher_assert.svh
// Assertion macros for the XXTEA block cipher.
// Each use names a label, an antecedent and a consequent; i_clk and i_rst_n
// must be visible where the macro is used.
`ifndef XXTEA_BLOCK_CIPHER_ASSERT_SVH
`define XXTEA_BLOCK_CIPHER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define XXTEA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("xxtea: same-cycle check failed");

// next-cycle implication
`define XXTEA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("xxtea: next-cycle check failed");

`else

`define XXTEA_ASSERT_IMP(lbl, ante, cons)
`define XXTEA_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### rtl/xxtea_pkg.sv
package xxtea_pkg;

    // block geometry
    localparam int BLOCK_WORDS = 8;
    localparam int WORD_W      = 32;
    localparam int STEP_W      = $clog2(BLOCK_WORDS);
    localparam int KEY_WORDS   = 4;
    localparam int KEY_IDX_W   = $clog2(KEY_WORDS);

    // round count is EXTRA_ROUNDS + 52 / BLOCK_WORDS
    localparam int DEF_EXTRA_ROUNDS = 16;
    localparam int BASE_ROUNDS      = 52 / BLOCK_WORDS;

    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

    // mode codes
    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    typedef logic [WORD_W-1:0]                   t_word;
    typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0]  t_block;
    typedef logic [KEY_WORDS-1:0][WORD_W-1:0]    t_key;

    // controller to datapath commands
    typedef struct packed {
        logic              load;       // capture a new block
        logic              step;       // one word update
        logic              round_end;  // last word of the current round
        logic              out_load;   // move the finished block to the output register
        logic [STEP_W-1:0] step_idx;   // word position within the round
    } t_dp_cmd;

    // XXTEA mixing function
    function automatic t_word mx(input t_word y, input t_word z, input t_word sum,
                                 input t_word k);
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        a  = (z >> 5) ^ (y << 2);
        b  = (y >> 3) ^ (z << 4);
        c  = sum ^ y;
        d  = k ^ z;
        mx = (a + b) ^ (c + d);
    endfunction

endpackage

### rtl/xxtea_block_cipher.sv
// XXTEA cipher on one 8-word (256-bit) block under a 128-bit key written
// through the config port (indexes 0..3, always ready; write only while idle).
// i_mode 0 enciphers, 1 deciphers. Rounds = EXTRA_ROUNDS + 6 (22 by default);
// one word update per clock through a single mixing unit (but for the hold on
// the last step below), after the block has been loaded in the idle state.
// The next block is taken as soon as the previous one leaves the working
// registers; a finished result waits in its own output register, and the
// last step of a block holds while that register is still occupied.
module xxtea_block_cipher
    import xxtea_pkg::*;
#(
    parameter int EXTRA_ROUNDS = DEF_EXTRA_ROUNDS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // block in
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_mode,
    input  logic [WORD_W-1:0]    i_word0,
    input  logic [WORD_W-1:0]    i_word1,
    input  logic [WORD_W-1:0]    i_word2,
    input  logic [WORD_W-1:0]    i_word3,
    input  logic [WORD_W-1:0]    i_word4,
    input  logic [WORD_W-1:0]    i_word5,
    input  logic [WORD_W-1:0]    i_word6,
    input  logic [WORD_W-1:0]    i_word7,
    // block out
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [WORD_W-1:0]    o_out_word0,
    output logic [WORD_W-1:0]    o_out_word1,
    output logic [WORD_W-1:0]    o_out_word2,
    output logic [WORD_W-1:0]    o_out_word3,
    output logic [WORD_W-1:0]    o_out_word4,
    output logic [WORD_W-1:0]    o_out_word5,
    output logic [WORD_W-1:0]    o_out_word6,
    output logic [WORD_W-1:0]    o_out_word7,
    // key writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [KEY_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

`include "xxtea_block_cipher_assert.svh"

    t_dp_cmd cmd;
    t_block  in_block;
    t_block  out_block;

    assign in_block = {i_word7, i_word6, i_word5, i_word4,
                       i_word3, i_word2, i_word1, i_word0};

    assign o_cfg_ready = 1'b1;

    xxtea_ctrl #(
        .EXTRA_ROUNDS (EXTRA_ROUNDS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    xxtea_dp #(
        .EXTRA_ROUNDS (EXTRA_ROUNDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_mode      (i_mode),
        .i_block     (in_block),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_block     (out_block)
    );

    assign o_out_word0 = out_block[0];
    assign o_out_word1 = out_block[1];
    assign o_out_word2 = out_block[2];
    assign o_out_word3 = out_block[3];
    assign o_out_word4 = out_block[4];
    assign o_out_word5 = out_block[5];
    assign o_out_word6 = out_block[6];
    assign o_out_word7 = out_block[7];

    // a load happens only on an input transfer, and the block is busy after it
    `XXTEA_ASSERT_IMP(a_load_on_transfer, cmd.load, i_valid && o_ready)
    `XXTEA_ASSERT_NXT(a_busy_after_load, cmd.load, !o_ready)
    // a finished block never overwrites a result that has not been taken
    `XXTEA_ASSERT_IMP(a_no_overwrite, cmd.out_load, !o_valid || i_ready)
    `XXTEA_ASSERT_NXT(a_valid_after_finish, cmd.out_load, o_valid && o_ready)

endmodule

### rtl/xxtea_ctrl.sv
module xxtea_ctrl
    import xxtea_pkg::*;
#(
    parameter int EXTRA_ROUNDS = DEF_EXTRA_ROUNDS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_dp_cmd o_cmd
);

    localparam int ROUNDS  = EXTRA_ROUNDS + BASE_ROUNDS;
    localparam int ROUND_W = $clog2(ROUNDS);
    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);
    localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(BLOCK_WORDS - 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [ROUND_W-1:0]  r_round, n_round;
    logic                r_out_valid, n_out_valid;

    logic round_end;
    logic last;
    logic slot_free;

    assign round_end = (r_step == LAST_STEP);
    assign last      = round_end && (r_round == LAST_ROUND);
    assign slot_free = !r_out_valid || i_ready;

    // next-state and command logic
    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        n_round        = r_round;
        n_out_valid    = r_out_valid && !i_ready;
        o_cmd          = '0;
        o_cmd.step_idx = r_step;
        o_cmd.round_end = round_end;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_round    = '0;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                // hold the final step while the previous result is still waiting
                if (!last || slot_free) begin
                    o_cmd.step = 1'b1;
                    n_step     = r_step + 1'b1;
                    if (round_end) begin
                        n_round = r_round + 1'b1;
                    end
                    if (last) begin
                        o_cmd.out_load = 1'b1;
                        n_out_valid    = 1'b1;
                        n_state        = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

### rtl/xxtea_dp.sv
module xxtea_dp
    import xxtea_pkg::*;
#(
    parameter int EXTRA_ROUNDS = DEF_EXTRA_ROUNDS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic                 i_mode,
    input  t_block               i_block,
    input  logic                 i_cfg_we,
    input  logic [KEY_IDX_W-1:0] i_cfg_index,
    input  t_word                i_cfg_data,
    output t_block               o_block
);

    localparam int ROUNDS = EXTRA_ROUNDS + BASE_ROUNDS;
    localparam logic [2*WORD_W-1:0] DEC_PROD = (2*WORD_W)'(ROUNDS) * (2*WORD_W)'(TEA_DELTA);
    localparam t_word DEC_SUM0 = DEC_PROD[WORD_W-1:0];
    localparam logic [STEP_W-1:0] LAST_POS = STEP_W'(BLOCK_WORDS - 1);

    t_key   r_key;
    t_block r_v, n_v;
    t_block r_out;
    t_word  r_sum;
    logic   r_mode;

    t_word             y, z, cur, upd, mix_val;
    logic [STEP_W-1:0] p;
    logic [1:0]        e;
    logic [KEY_IDX_W-1:0] kidx;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            r_key[i_cfg_index] <= i_cfg_data;
        end
    end

    // taps of the rotating word line: encrypt works at the bottom, decrypt at the top
    always_comb begin
        if (r_mode == MODE_ENC) begin
            cur = r_v[0];
            y   = r_v[1];
            z   = r_v[BLOCK_WORDS-1];
            p   = i_cmd.step_idx;
        end else begin
            cur = r_v[BLOCK_WORDS-1];
            y   = r_v[0];
            z   = r_v[BLOCK_WORDS-2];
            p   = LAST_POS - i_cmd.step_idx;
        end
        e       = r_sum[3:2];
        kidx    = p[KEY_IDX_W-1:0] ^ e;
        mix_val = mx(y, z, r_sum, r_key[kidx]);
        upd     = (r_mode == MODE_ENC) ? (cur + mix_val) : (cur - mix_val);
    end

    // rotate by one word per step
    always_comb begin
        if (r_mode == MODE_ENC) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                n_v[i] = r_v[i+1];
            end
            n_v[BLOCK_WORDS-1] = upd;
        end else begin
            for (int i = 1; i < BLOCK_WORDS; i++) begin
                n_v[i] = r_v[i-1];
            end
            n_v[0] = upd;
        end
    end

    // working block, mode and round sum
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v    <= i_block;
            r_mode <= i_mode;
            r_sum  <= (i_mode == MODE_ENC) ? TEA_DELTA : DEC_SUM0;
        end else if (i_cmd.step) begin
            r_v <= n_v;
            if (i_cmd.round_end) begin
                r_sum <= (r_mode == MODE_ENC) ? (r_sum + TEA_DELTA) : (r_sum - TEA_DELTA);
            end
        end
    end

    // result register, apart from the working block
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= n_v;
        end
    end

    assign o_block = r_out;

endmodule
